FILE: design/cps_pkg.sv
// Shared constants and codes for the chain preemption sequencer.
`timescale 1ns / 1ps

package cps_pkg;

	// Ring limits and field widths.
	localparam int MAX_STREAMS = 64;
	localparam int IDX_W       = 6;
	localparam int CNT_W       = 7;
	localparam int MASK_W      = 64;

	// Configuration port geometry.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Register indexes, taken from paddr[2].
	localparam logic REG_STREAM_COUNT   = 1'b0;
	localparam logic REG_TIMERS_RUNNING = 1'b1;

	// Event kinds.
	localparam logic KIND_STREAM    = 1'b0;
	localparam logic KIND_DEDICATED = 1'b1;

endpackage

FILE: design/cps_tick_if.sv
// Handshake interfaces for tick words in and result words out.
`timescale 1ns / 1ps

interface cps_tick_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [cps_pkg::IDX_W-1:0]   stream_index;
	logic [cps_pkg::MASK_W-1:0]  preemptive_mask;
	logic                        in_runtime;

	modport source (output valid, kind, stream_index, preemptive_mask, in_runtime,
		input ready);
	modport sink (input valid, kind, stream_index, preemptive_mask, in_runtime,
		output ready);
endinterface

interface cps_result_if;
	logic                      valid;
	logic                      ready;
	logic                      accepted;
	logic                      kill_valid;
	logic [cps_pkg::IDX_W-1:0] kill_index;
	logic                      preempt_self;

	modport source (output valid, accepted, kill_valid, kill_index, preempt_self,
		input ready);
	modport sink (input valid, accepted, kill_valid, kill_index, preempt_self,
		output ready);
endinterface

FILE: design/chain_preemption_sequencer.sv
// Top level of the chain preemption sequencer: input stage, ring search, result register.
//
//  Channel     Direction  Word contents
//  tick_in     in         kind, stream_index, preemptive_mask, in_runtime
//  result_out  out        accepted, kill_valid, kill_index, preempt_self
//  APB         in/out     stream_count (0x0), timers_running (0x4)
//
// One tick word is taken per cycle unless the output stalls; the input stage holds it.
// The rotated find-first-set over the 64-bit mask sits between the input stage
// and the result register, and the chain state updates at the same edge.
// Reset clears the chain state and sets stream_count to 1 and timers_running to 0.
// A stalled result holds the result register; the input stage still fills behind it.
`timescale 1ns / 1ps

module chain_preemption_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	cps_tick_if.sink                    tick_in,
	cps_result_if.source                result_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cps_pkg::ADDR_W-1:0]  paddr,
	input  logic [cps_pkg::DATA_W-1:0]  pwdata,
	output logic [cps_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	localparam int IW = cps_pkg::IDX_W;
	localparam int CW = cps_pkg::CNT_W;
	localparam int MW = cps_pkg::MASK_W;

	// Bits p with lo <= p < hi.
	function automatic logic [MW-1:0] range_mask(input logic [CW-1:0] lo,
		input logic [CW-1:0] hi);
		logic [MW-1:0] m;
		for (int p = 0; p < MW; p++) begin
			m[p] = (CW'(p) >= lo) && (CW'(p) < hi);
		end
		return m;
	endfunction

	// Lowest set bit, with a found flag in the top bit.
	function automatic logic [IW:0] first_set(input logic [MW-1:0] m);
		logic [IW:0] r;
		r = '0;
		for (int p = MW - 1; p >= 0; p--) begin
			if (m[p]) begin
				r = {1'b1, IW'(p)};
			end
		end
		return r;
	endfunction

	// Configuration registers and chain state.
	logic [CW-1:0] stream_count_q;
	logic          timers_running_q;
	logic          chain_active_q;
	logic          next_valid_q;
	logic [IW-1:0] next_position_q;
	logic [IW-1:0] stop_position_q;

	// Input stage.
	logic          valid_s1;
	logic          kind_s1;
	logic [IW-1:0] index_s1;
	logic [MW-1:0] mask_s1;
	logic          in_runtime_s1;

	// Result register.
	logic          out_valid_q;
	logic          accepted_q;
	logic          kill_valid_q;
	logic [IW-1:0] kill_index_q;
	logic          preempt_self_q;

	logic cfg_write;
	logic advance;
	logic in_ready;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	// Register read back.
	always_comb begin
		case (paddr[2])
			cps_pkg::REG_STREAM_COUNT:   prdata = cps_pkg::DATA_W'(stream_count_q);
			cps_pkg::REG_TIMERS_RUNNING: prdata = cps_pkg::DATA_W'(timers_running_q);
			default:                     prdata = '0;
		endcase
	end

	// Handshake: the input stage moves whenever the result register is free or drained.
	assign advance        = !out_valid_q || result_out.ready;
	assign in_ready       = !valid_s1 || advance;
	assign tick_in.ready  = in_ready;

	// Effective ring size, 1..MAX_STREAMS.
	logic [CW-1:0] ring_n;
	always_comb begin
		if (stream_count_q == '0) begin
			ring_n = CW'(1);
		end else if (stream_count_q > CW'(cps_pkg::MAX_STREAMS)) begin
			ring_n = CW'(cps_pkg::MAX_STREAMS);
		end else begin
			ring_n = stream_count_q;
		end
	end

	// Ring search for both event kinds.
	logic [CW-1:0] idx7;
	logic [CW-1:0] stop7;
	logic          stop_ahead;
	logic [CW-1:0] hi_end;
	logic [CW-1:0] lo_end;
	logic [IW:0]   first_hit;
	logic [IW:0]   hi_hit;
	logic [IW:0]   lo_hit;
	logic [IW:0]   ring_hit;
	logic          idx_in_ring;
	logic          in_order;

	always_comb begin
		idx7        = CW'(index_s1);
		stop7       = chain_active_q ? CW'(stop_position_q) : idx7;
		stop_ahead  = (stop7 > idx7) && (stop7 < ring_n);
		hi_end      = stop_ahead ? stop7 : ring_n;
		lo_end      = stop_ahead ? '0 : ((stop7 < idx7) ? stop7 : idx7);
		first_hit   = first_set(mask_s1 & range_mask('0, ring_n));
		hi_hit      = first_set(mask_s1 & range_mask(idx7 + CW'(1), hi_end));
		lo_hit      = first_set(mask_s1 & range_mask('0, lo_end));
		ring_hit    = hi_hit[IW] ? hi_hit : lo_hit;
		idx_in_ring = idx7 < ring_n;
		in_order    = !next_valid_q || (next_position_q == index_s1);
	end

	// Input stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= tick_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && tick_in.valid) begin
			kind_s1       <= tick_in.kind;
			index_s1      <= tick_in.stream_index;
			mask_s1       <= tick_in.preemptive_mask;
			in_runtime_s1 <= tick_in.in_runtime;
		end
	end

	// Chain state, configuration and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_count_q   <= CW'(1);
			timers_running_q <= 1'b0;
			chain_active_q   <= 1'b0;
			next_valid_q     <= 1'b0;
			next_position_q  <= '0;
			stop_position_q  <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (cfg_write) begin
				case (paddr[2])
					cps_pkg::REG_STREAM_COUNT: begin
						stream_count_q <= pwdata[CW-1:0];
					end
					cps_pkg::REG_TIMERS_RUNNING: begin
						timers_running_q <= pwdata[0];
						chain_active_q   <= 1'b0;
						next_valid_q     <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (advance && valid_s1) begin
				if (kind_s1 == cps_pkg::KIND_DEDICATED) begin
					// A dedicated tick starts a chain at the lowest preemptible stream.
					if (!chain_active_q && first_hit[IW]) begin
						chain_active_q  <= 1'b1;
						next_valid_q    <= 1'b1;
						next_position_q <= first_hit[IW-1:0];
						stop_position_q <= '0;
					end
				end else if (timers_running_q && idx_in_ring) begin
					if (!in_order) begin
						// Out-of-order tick drops the chain.
						chain_active_q <= 1'b0;
						next_valid_q   <= 1'b0;
					end else begin
						if (!chain_active_q) begin
							stop_position_q <= index_s1;
						end
						if (ring_hit[IW]) begin
							chain_active_q  <= 1'b1;
							next_valid_q    <= 1'b1;
							next_position_q <= ring_hit[IW-1:0];
						end else begin
							chain_active_q <= 1'b0;
							next_valid_q   <= 1'b0;
						end
					end
				end
			end
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			accepted_q     <= 1'b0;
			kill_valid_q   <= 1'b0;
			kill_index_q   <= '0;
			preempt_self_q <= 1'b0;
			if (kind_s1 == cps_pkg::KIND_DEDICATED) begin
				if (!chain_active_q && first_hit[IW]) begin
					kill_valid_q <= 1'b1;
					kill_index_q <= first_hit[IW-1:0];
				end
			end else if (timers_running_q && idx_in_ring && in_order) begin
				accepted_q     <= 1'b1;
				preempt_self_q <= !in_runtime_s1;
				if (ring_hit[IW]) begin
					kill_valid_q <= 1'b1;
					kill_index_q <= ring_hit[IW-1:0];
				end
			end
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.accepted     = accepted_q;
	assign result_out.kill_valid   = kill_valid_q;
	assign result_out.kill_index   = kill_index_q;
	assign result_out.preempt_self = preempt_self_q;

endmodule

FILE: design/cps_checker.sv
// Port-level assertions for the chain preemption sequencer, and their bind.
`timescale 1ns / 1ps

module cps_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      accepted,
	input logic                      kill_valid,
	input logic [cps_pkg::IDX_W-1:0] kill_index,
	input logic                      preempt_self
);

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kill_index) && $stable(kill_valid)
			&& $stable(accepted) && $stable(preempt_self))
		else $error("result word changed while stalled");

	// A stream only preempts itself on an accepted tick.
	a_self_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && preempt_self |-> accepted)
		else $error("preempt_self without accepted");

	// Without a kill the index reads zero.
	a_kill_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kill_valid |-> kill_index == '0)
		else $error("kill_index set without kill_valid");

	// An empty result register never holds back the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty result register");

endmodule

bind chain_preemption_sequencer cps_checker u_cps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (tick_in.ready),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.accepted     (result_out.accepted),
	.kill_valid   (result_out.kill_valid),
	.kill_index   (result_out.kill_index),
	.preempt_self (result_out.preempt_self)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the chain preemption sequencer with directed and random tick words.
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 85;

	localparam int IW = cps_pkg::IDX_W;
	localparam int CW = cps_pkg::CNT_W;
	localparam int MW = cps_pkg::MASK_W;
	localparam int AW = cps_pkg::ADDR_W;
	localparam int DW = cps_pkg::DATA_W;

	// One tick word as offered on the input channel.
	typedef struct packed {
		logic          kind;
		logic [IW-1:0] stream_index;
		logic [MW-1:0] mask;
		logic          in_runtime;
	} tick_t;

	// One decision word as expected on the result channel.
	typedef struct packed {
		logic          accepted;
		logic          kill_valid;
		logic [IW-1:0] kill_index;
		logic          preempt_self;
	} decision_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [AW-1:0] paddr;
	logic [DW-1:0] pwdata;
	logic [DW-1:0] prdata;
	logic          pready;

	cps_tick_if   tick_bus ();
	cps_result_if decision_bus ();

	chain_preemption_sequencer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_in    (tick_bus),
		.result_out (decision_bus),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// Mirror of the chain state and the two registers.
	logic [CW-1:0] ring_count_reg;
	logic          timers_on;
	logic          chain_on;
	logic          next_known;
	logic [IW-1:0] next_pos;
	logic [IW-1:0] stop_pos;

	decision_t decision_q[$];
	int        error_count = 0;
	int        cycle_count = 0;
	int        hold_seq    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Effective ring size: zero acts as one, large values clip to the maximum.
	function automatic int ring_size();
		if (ring_count_reg == 0)
			return 1;
		if (ring_count_reg > cps_pkg::MAX_STREAMS)
			return cps_pkg::MAX_STREAMS;
		return int'(ring_count_reg);
	endfunction

	// Advance the chain state for one accepted tick and return the decision it causes.
	function automatic decision_t chain_step(tick_t t);
		decision_t d;
		int        n;
		int        i;
		int        pos;
		logic      found;
		d = '0;
		n = ring_size();
		if (t.kind == cps_pkg::KIND_DEDICATED) begin
			if (!chain_on) begin
				for (i = 0; i < n; i++) begin
					if (t.mask[i]) begin
						next_known   = 1'b1;
						next_pos     = IW'(i);
						stop_pos     = '0;
						chain_on     = 1'b1;
						d.kill_valid = 1'b1;
						d.kill_index = IW'(i);
						break;
					end
				end
			end
		end else if (timers_on && int'(t.stream_index) < n) begin
			if (next_known && next_pos != t.stream_index) begin
				// Out-of-order tick drops the chain.
				next_known = 1'b0;
				chain_on   = 1'b0;
			end else begin
				d.accepted = 1'b1;
				if (!chain_on) begin
					chain_on = 1'b1;
					stop_pos = t.stream_index;
				end
				pos   = int'(t.stream_index);
				found = 1'b0;
				for (i = 1; i < n; i++) begin
					pos = (pos + 1 == n) ? 0 : pos + 1;
					if (pos == int'(stop_pos))
						break;
					if (t.mask[pos]) begin
						found = 1'b1;
						break;
					end
				end
				if (found) begin
					next_known   = 1'b1;
					next_pos     = IW'(pos);
					d.kill_valid = 1'b1;
					d.kill_index = IW'(pos);
				end else begin
					chain_on   = 1'b0;
					next_known = 1'b0;
				end
			end
		end
		d.preempt_self = d.accepted && !t.in_runtime;
		return d;
	endfunction

	function automatic tick_t make_tick(logic kind, logic [IW-1:0] idx, logic [MW-1:0] mask,
		logic in_rt);
		tick_t t;
		t.kind         = kind;
		t.stream_index = idx;
		t.mask         = mask;
		t.in_runtime   = in_rt;
		return t;
	endfunction

	// Masks of several densities; the single-bit styles keep the hit inside the ring.
	function automatic logic [MW-1:0] rand_mask(int n);
		logic [MW-1:0] m;
		case ($urandom_range(0, 5))
			0: m = {$urandom, $urandom};
			1: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			2: begin
				m = '0;
				m[$urandom_range(0, n - 1)] = 1'b1;
			end
			3: begin
				m = '0;
				m[$urandom_range(0, n - 1)] = 1'b1;
				m[$urandom_range(0, MW - 1)] = 1'b1;
			end
			4: m = '0;
			default: m = '1;
		endcase
		return m;
	endfunction

	// Mostly follows the chain the block expects; the rest is out-of-order ticks and noise.
	function automatic tick_t next_tick();
		int n;
		int r;
		n = ring_size();
		r = $urandom_range(0, 99);
		if (chain_on && next_known && r < 80)
			return make_tick(cps_pkg::KIND_STREAM, next_pos, rand_mask(n),
				1'($urandom_range(0, 1)));
		if (!chain_on && r < 50)
			return make_tick(cps_pkg::KIND_DEDICATED, IW'($urandom_range(0, 63)),
				rand_mask(n), 1'($urandom_range(0, 1)));
		if (r < 85)
			return make_tick(cps_pkg::KIND_STREAM, IW'($urandom_range(0, n - 1)),
				rand_mask(n), 1'($urandom_range(0, 1)));
		return make_tick(1'($urandom_range(0, 1)), IW'($urandom_range(0, 63)),
			{$urandom, $urandom}, 1'($urandom_range(0, 1)));
	endfunction

	// Offer one word and record its expected decision once it is taken.
	// Valid stays high afterwards so that back-to-back words need no extra step.
	task automatic send_tick(tick_t t);
		tick_bus.valid           <= 1'b1;
		tick_bus.kind            <= t.kind;
		tick_bus.stream_index    <= t.stream_index;
		tick_bus.preemptive_mask <= t.mask;
		tick_bus.in_runtime      <= t.in_runtime;
		do @(posedge clk); while (tick_bus.ready !== 1'b1);
		decision_q.push_back(chain_step(t));
	endtask

	task automatic idle(int cycles);
		tick_bus.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending, wait for every expected decision, then wait out the output latency.
	task automatic drain();
		tick_bus.valid <= 1'b0;
		while (decision_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic reg_sel, logic [DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == cps_pkg::REG_STREAM_COUNT) begin
			ring_count_reg = data[CW-1:0];
		end else begin
			timers_on  = data[0];
			chain_on   = 1'b0;
			next_known = 1'b0;
		end
		@(posedge clk);
	endtask

	// Upper data bits are random; only the register's own bits should matter.
	task automatic set_ring(int count);
		logic [DW-1:0] data;
		data = $urandom;
		data[CW-1:0] = CW'(count);
		apb_write(cps_pkg::REG_STREAM_COUNT, data);
	endtask

	task automatic set_timers(logic on);
		logic [DW-1:0] data;
		data = $urandom;
		data[0] = on;
		apb_write(cps_pkg::REG_TIMERS_RUNNING, data);
	endtask

	// Reset values: one stream, timers stopped.
	task automatic test_reset_defaults();
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(0), '1, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_DEDICATED, IW'(0), '0, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_DEDICATED, IW'(5), 64'h2, 1'b1));
		send_tick(make_tick(cps_pkg::KIND_DEDICATED, IW'(63), '1, 1'b1));
		send_tick(make_tick(cps_pkg::KIND_DEDICATED, IW'(0), '1, 1'b0));
		drain();
	endtask

	// A full chain walk, an out-of-order drop and ticks outside the ring.
	task automatic test_chain_walk();
		set_ring(4);
		set_timers(1'b1);
		send_tick(make_tick(cps_pkg::KIND_DEDICATED, IW'(0), 64'hA, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_DEDICATED, IW'(0), 64'hA, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(1), 64'hA, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(3), 64'hA, 1'b1));
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(2), '1, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(1), '1, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(5), '1, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(63), '1, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_DEDICATED, IW'(0), 64'hFFFF_FFFF_FFFF_FFF0, 1'b0));
		drain();
	endtask

	// Ring size clipping, an unreachable stop stream and chain clearing by a timer write.
	task automatic test_ring_limits();
		set_ring(0);
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(0), '1, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(1), '1, 1'b0));
		drain();
		set_ring(127);
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(63), 64'h1, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(0), 64'h8000_0000_0000_0000, 1'b0));
		drain();
		// Chain stops at stream 50, then the ring shrinks below it.
		set_ring(64);
		set_timers(1'b1);
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(50), 64'h8, 1'b0));
		drain();
		set_ring(8);
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(3), '0, 1'b1));
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(2), 64'h10, 1'b0));
		drain();
		set_timers(1'b1);
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(6), '0, 1'b0));
		drain();
		// Stream ticks need the timers; the dedicated tick does not.
		set_timers(1'b0);
		send_tick(make_tick(cps_pkg::KIND_STREAM, IW'(0), '1, 1'b0));
		send_tick(make_tick(cps_pkg::KIND_DEDICATED, IW'(0), 64'h1, 1'b0));
		drain();
	endtask

	// The receiver holds off for a long stretch while words keep coming.
	task automatic test_backpressure();
		set_ring(64);
		set_timers(1'b1);
		hold_seq++;
		repeat (60) send_tick(next_tick());
		drain();
		set_ring(6);
		set_timers(1'b1);
		hold_seq++;
		repeat (40) send_tick(next_tick());
		drain();
	endtask

	task automatic run_random_phase(int items);
		int burst;
		burst = 0;
		repeat (items) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0)
					idle($urandom_range(1, 8));
			end
			burst--;
			send_tick(next_tick());
		end
		drain();
	endtask

	// Random chains over a range of ring sizes, extremes included.
	task automatic test_random_chains();
		int counts[14];
		int p;
		counts = '{1, 2, 3, 4, 5, 8, 17, 33, 63, 64, 0, 127, 65, 0};
		counts[13] = $urandom_range(0, 127);
		for (p = 0; p < 14; p++) begin
			set_ring(counts[p]);
			set_timers(1'b1);
			run_random_phase(PHASE_ITEMS);
		end
	endtask

	// Compare each decision word with the oldest expectation.
	always @(posedge clk) begin : decision_check
		decision_t want;
		if (decision_bus.valid === 1'b1 && decision_bus.ready === 1'b1) begin
			if (decision_q.size() == 0) begin
				error_count++;
				$error("decision word arrived with nothing expected");
			end else begin
				want = decision_q.pop_front();
				if (decision_bus.accepted !== want.accepted) begin
					error_count++;
					$error("accepted: expected %0d, got %0d", want.accepted,
						decision_bus.accepted);
				end
				if (decision_bus.kill_valid !== want.kill_valid) begin
					error_count++;
					$error("kill_valid: expected %0d, got %0d", want.kill_valid,
						decision_bus.kill_valid);
				end
				if (decision_bus.kill_index !== want.kill_index) begin
					error_count++;
					$error("kill_index: expected %0d, got %0d", want.kill_index,
						decision_bus.kill_index);
				end
				if (decision_bus.preempt_self !== want.preempt_self) begin
					error_count++;
					$error("preempt_self: expected %0d, got %0d", want.preempt_self,
						decision_bus.preempt_self);
				end
			end
		end
	end

	// Receiver ready: changing stall patterns, plus long holds on request.
	initial begin : decision_receiver
		int mode;
		int mode_left;
		int hold_left;
		int seen_hold;
		int beat;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		seen_hold = 0;
		beat      = 0;
		decision_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			beat++;
			if (hold_seq != seen_hold) begin
				seen_hold = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				decision_bus.ready <= 1'b0;
			end else begin
				case (mode)
					0: decision_bus.ready <= 1'b1;
					1: decision_bus.ready <= 1'($urandom_range(0, 1));
					2: decision_bus.ready <= ($urandom_range(0, 3) == 0);
					default: decision_bus.ready <= (beat % 5 != 0);
				endcase
			end
		end
	end

	initial begin : test_sequence
		ring_count_reg = CW'(1);
		timers_on      = 1'b0;
		chain_on       = 1'b0;
		next_known     = 1'b0;
		next_pos       = '0;
		stop_pos       = '0;
		arst_n                   <= 1'b0;
		tick_bus.valid           <= 1'b0;
		tick_bus.kind            <= cps_pkg::KIND_STREAM;
		tick_bus.stream_index    <= '0;
		tick_bus.preemptive_mask <= '0;
		tick_bus.in_runtime      <= 1'b0;
		psel                     <= 1'b0;
		penable                  <= 1'b0;
		pwrite                   <= 1'b0;
		paddr                    <= '0;
		pwdata                   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_chain_walk();
		test_ring_limits();
		test_backpressure();
		test_random_chains();

		drain();
		repeat (10) @(posedge clk);
		if (error_count == 0 && decision_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
